// File: hdl/gaps_pkg.sv
// shared types and codes of the grid path search unit
// no dependencies; imported by every module of the block
package gaps_pkg;

  // width of an effective grid dimension (holds up to 511)
  localparam int DIM_W = 9;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0]  CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET   = 7'd64;

  // item kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_PATH = 2'd1;
  localparam logic [1:0] ST_BEYOND  = 2'd2;

  // neighbor order: up, down, left, right
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  cell_col;
    logic [5:0]  cell_row;
    logic [5:0]  goal_col;
    logic [5:0]  goal_row;
    logic        blocked;
    logic [11:0] step_index;
  } gaps_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] path_length;
    logic [5:0]  step_col;
    logic [5:0]  step_row;
  } gaps_out_t;

  // open list commands and status
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } heap_cmd_t;

  typedef struct packed {
    logic busy;
    logic empty;
  } heap_sts_t;

  typedef enum logic [2:0] {
    HP_IDLE,
    HP_UP_RD,
    HP_UP_CMP,
    HP_POP_TOP,
    HP_POP_LAST,
    HP_DN_L,
    HP_DN_R,
    HP_DN_CMP
  } heap_state_t;

  typedef enum logic [4:0] {
    CS_CLR_MAP,
    CS_IDLE,
    CS_WRITE,
    CS_READ,
    CS_READ_WAIT,
    CS_S_CHK,
    CS_S_GOAL,
    CS_S_SWEEP,
    CS_S_SEED,
    CS_POP_CHK,
    CS_POP_WAIT,
    CS_CUR,
    CS_NB,
    CS_NB_CHK,
    CS_NB_WAIT,
    CS_TRACE,
    CS_TRACE_WAIT,
    CS_FILL,
    CS_FILL_WAIT,
    CS_DONE
  } core_state_t;

endpackage

// File: hdl/gaps_heap.sv
// open list of the search: binary min-heap in one synchronous memory
// ordered by cost, then by push order; depends on gaps_pkg
module gaps_heap #(
  parameter int HEAP_DEPTH = 16384,
  parameter int FW         = 14,
  parameter int SQW        = 15,
  parameter int RW         = 6,
  parameter int CLW        = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gaps_pkg::heap_cmd_t cmd,
  input  logic [FW-1:0]       push_f,
  input  logic [RW-1:0]       push_row,
  input  logic [CLW-1:0]      push_col,
  output gaps_pkg::heap_sts_t sts,
  output logic [RW-1:0]       pop_row,
  output logic [CLW-1:0]      pop_col
);
  import gaps_pkg::*;

  localparam int HW = $clog2(HEAP_DEPTH);

  typedef struct packed {
    logic [FW-1:0]  f;
    logic [SQW-1:0] seq;
    logic [RW-1:0]  row;
    logic [CLW-1:0] col;
  } entry_t;

  function automatic logic less(entry_t a, entry_t b);
    return (a.f < b.f) || ((a.f == b.f) && (a.seq < b.seq));
  endfunction

  entry_t heap_mem [HEAP_DEPTH];
  entry_t rd_q_r;
  logic [HW-1:0] rd_addr;
  logic          we;
  logic [HW-1:0] wr_addr;
  entry_t        wr_data;

  heap_state_t    st_r, st_nxt;
  logic [HW:0]    cnt_r, cnt_nxt;
  logic [SQW-1:0] seq_r, seq_nxt;
  logic [HW-1:0]  idx_r, idx_nxt;
  logic [HW-1:0]  par_r, par_nxt;
  entry_t         elem_r, elem_nxt;
  entry_t         lft_r, lft_nxt;
  entry_t         top_r, top_nxt;
  logic           has_rt_r, has_rt_nxt;

  logic          push_ok;
  logic [HW-1:0] par_idx;
  logic [HW+1:0] lidx, ridx;
  logic          take_l, take_r;
  entry_t        best_lm;

  // index arithmetic and child selection
  assign push_ok = cmd.push && (cnt_r < (HW+1)'(HEAP_DEPTH));
  assign par_idx = (idx_r - HW'(1)) >> 1;
  assign lidx    = (HW+2)'({idx_r, 1'b1});
  assign ridx    = lidx + (HW+2)'(1);
  assign take_l  = less(lft_r, elem_r);
  assign best_lm = take_l ? lft_r : elem_r;
  assign take_r  = has_rt_r && less(rd_q_r, best_lm);

  // heap memory
  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_q_r <= heap_mem[rd_addr];
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      HP_IDLE: begin
        if (cmd.clear) begin
          st_nxt = HP_IDLE;
        end else if (push_ok) begin
          st_nxt = HP_UP_RD;
        end else if (cmd.pop) begin
          st_nxt = HP_POP_TOP;
        end
      end
      HP_UP_RD: begin
        if (idx_r == '0) st_nxt = HP_IDLE;
        else st_nxt = HP_UP_CMP;
      end
      HP_UP_CMP: begin
        if (less(elem_r, rd_q_r)) st_nxt = HP_UP_RD;
        else st_nxt = HP_IDLE;
      end
      HP_POP_TOP: begin
        if (cnt_r == '0) st_nxt = HP_IDLE;
        else st_nxt = HP_POP_LAST;
      end
      HP_POP_LAST: st_nxt = HP_DN_L;
      HP_DN_L: begin
        if (lidx >= (HW+2)'(cnt_r)) st_nxt = HP_IDLE;
        else st_nxt = HP_DN_R;
      end
      HP_DN_R: st_nxt = HP_DN_CMP;
      HP_DN_CMP: begin
        if (take_l || take_r) st_nxt = HP_DN_L;
        else st_nxt = HP_IDLE;
      end
      default: st_nxt = HP_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt    = cnt_r;
    seq_nxt    = seq_r;
    idx_nxt    = idx_r;
    par_nxt    = par_r;
    elem_nxt   = elem_r;
    lft_nxt    = lft_r;
    top_nxt    = top_r;
    has_rt_nxt = has_rt_r;
    rd_addr    = '0;
    we         = 1'b0;
    wr_addr    = idx_r;
    wr_data    = elem_r;
    unique case (st_r)
      HP_IDLE: begin
        if (cmd.clear) begin
          cnt_nxt = '0;
          seq_nxt = '0;
        end else if (push_ok) begin
          elem_nxt = '{f: push_f, seq: seq_r, row: push_row, col: push_col};
          seq_nxt  = seq_r + SQW'(1);
          idx_nxt  = HW'(cnt_r);
          cnt_nxt  = cnt_r + (HW+1)'(1);
        end else if (cmd.pop) begin
          cnt_nxt = cnt_r - (HW+1)'(1);
        end
      end
      HP_UP_RD: begin
        if (idx_r == '0) begin
          we = 1'b1;
        end else begin
          rd_addr = par_idx;
          par_nxt = par_idx;
        end
      end
      HP_UP_CMP: begin
        we = 1'b1;
        if (less(elem_r, rd_q_r)) begin
          wr_data = rd_q_r;
          idx_nxt = par_r;
        end
      end
      HP_POP_TOP: begin
        top_nxt = rd_q_r;
        rd_addr = HW'(cnt_r);
      end
      HP_POP_LAST: begin
        elem_nxt = rd_q_r;
        idx_nxt  = '0;
      end
      HP_DN_L: begin
        if (lidx >= (HW+2)'(cnt_r)) begin
          we = 1'b1;
        end else begin
          rd_addr = HW'(lidx);
        end
      end
      HP_DN_R: begin
        lft_nxt = rd_q_r;
        if (ridx < (HW+2)'(cnt_r)) begin
          rd_addr    = HW'(ridx);
          has_rt_nxt = 1'b1;
        end else begin
          has_rt_nxt = 1'b0;
        end
      end
      HP_DN_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wr_data = rd_q_r;
          idx_nxt = HW'(ridx);
        end else if (take_l) begin
          wr_data = lft_r;
          idx_nxt = HW'(lidx);
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= HP_IDLE;
      cnt_r <= '0;
      seq_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      seq_r <= seq_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    par_r    <= par_nxt;
    elem_r   <= elem_nxt;
    lft_r    <= lft_nxt;
    top_r    <= top_nxt;
    has_rt_r <= has_rt_nxt;
  end

  assign sts.busy  = (st_r != HP_IDLE);
  assign sts.empty = (cnt_r == '0);
  assign pop_row   = top_r.row;
  assign pop_col   = top_r.col;

endmodule

// File: hdl/gaps_core.sv
// search sequencer: obstacle map, per-cell node store and path store memories
// depends on gaps_pkg and gaps_heap
module gaps_core #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 64,
  parameter int HEAP_DEPTH = 16384
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  gaps_pkg::gaps_in_t           item,
  input  logic [gaps_pkg::DIM_W-1:0]   eff_w,
  input  logic [gaps_pkg::DIM_W-1:0]   eff_h,
  output logic                         ready,
  output logic                         res_valid,
  output gaps_pkg::gaps_out_t          res_data,
  input  logic                         res_take
);
  import gaps_pkg::*;

  localparam int CLW   = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int GW    = AW + 1;
  localparam int FW    = AW + 2;
  localparam int SQW   = AW + 3;

  typedef struct packed {
    logic [RW-1:0]  row;
    logic [CLW-1:0] col;
  } pos_t;

  typedef struct packed {
    logic          closed;
    logic [GW-1:0] cost;
    pos_t          parent;
  } node_t;

  function automatic logic [AW-1:0] cell_addr(pos_t p);
    return AW'(AW'(p.row) * AW'(MAX_COLS) + AW'(p.col));
  endfunction

  function automatic logic [FW-1:0] cost_to_go(pos_t a, pos_t b);
    logic [CLW-1:0] dc;
    logic [RW-1:0]  dr;
    dc = (a.col > b.col) ? (a.col - b.col) : (b.col - a.col);
    dr = (a.row > b.row) ? (a.row - b.row) : (b.row - a.row);
    return FW'(dc) + FW'(dr);
  endfunction

  // memories
  logic  obs_mem  [CELLS];
  node_t node_mem [CELLS];
  pos_t  path_mem [CELLS];

  logic          obs_q_r;
  node_t         node_q_r;
  pos_t          path_q_r;
  logic [AW-1:0] rd_cell;
  logic [AW-1:0] path_raddr;
  logic          obs_we, obs_wdata;
  logic [AW-1:0] obs_waddr;
  logic          node_we;
  logic [AW-1:0] node_waddr;
  node_t         node_wdata;
  logic          path_we;
  logic [AW-1:0] path_waddr;

  // sequencer registers
  core_state_t   st_r, st_nxt;
  gaps_in_t      item_r, item_nxt;
  pos_t          start_r, start_nxt;
  pos_t          goal_r, goal_nxt;
  pos_t          cur_r, cur_nxt;
  pos_t          nb_r, nb_nxt;
  pos_t          trc_r, trc_nxt;
  logic [GW-1:0] g_r, g_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [AW:0]   len_r, len_nxt;
  gaps_out_t     res_r, res_nxt;

  // open list
  heap_cmd_t      hcmd;
  heap_sts_t      hsts;
  logic [FW-1:0]  push_f;
  pos_t           push_pos;
  pos_t           pop_pos;

  gaps_heap #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .FW         (FW),
    .SQW        (SQW),
    .RW         (RW),
    .CLW        (CLW)
  ) u_heap (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (hcmd),
    .push_f   (push_f),
    .push_row (push_pos.row),
    .push_col (push_pos.col),
    .sts      (hsts),
    .pop_row  (pop_pos.row),
    .pop_col  (pop_pos.col)
  );

  // decoded conditions
  pos_t          item_start, item_goal;
  logic          s_oob, wr_in, rd_in, sweep_last, trace_end, relax;
  logic          nb_ok;
  pos_t          nb_pos;
  logic [GW-1:0] ng;

  assign item_start = '{row: RW'(item_r.cell_row), col: CLW'(item_r.cell_col)};
  assign item_goal  = '{row: RW'(item_r.goal_row), col: CLW'(item_r.goal_col)};
  assign s_oob = (DIM_W'(item_r.cell_col) >= eff_w) || (DIM_W'(item_r.cell_row) >= eff_h) ||
                 (DIM_W'(item_r.goal_col) >= eff_w) || (DIM_W'(item_r.goal_row) >= eff_h);
  assign wr_in = (DIM_W'(item_r.cell_col) < DIM_W'(MAX_COLS)) &&
                 (DIM_W'(item_r.cell_row) < DIM_W'(MAX_ROWS));
  assign rd_in      = (32'(item_r.step_index) < 32'(len_r));
  assign sweep_last = (cnt_r == (AW+1)'(CELLS - 1));
  assign trace_end  = (trc_r == start_r) || (cnt_r == (AW+1)'(CELLS));
  assign ng         = g_r + GW'(1);
  assign relax      = !obs_q_r && !node_q_r.closed && (ng < node_q_r.cost);

  // neighbor of the current cell in the current direction
  always_comb begin
    nb_pos = cur_r;
    nb_ok  = 1'b0;
    unique case (dir_r)
      DIR_UP: begin
        nb_ok      = (cur_r.row != '0);
        nb_pos.row = cur_r.row - RW'(1);
      end
      DIR_DOWN: begin
        nb_ok      = ((DIM_W'(cur_r.row) + DIM_W'(1)) < eff_h);
        nb_pos.row = cur_r.row + RW'(1);
      end
      DIR_LEFT: begin
        nb_ok      = (cur_r.col != '0);
        nb_pos.col = cur_r.col - CLW'(1);
      end
      DIR_RIGHT: begin
        nb_ok      = ((DIM_W'(cur_r.col) + DIM_W'(1)) < eff_w);
        nb_pos.col = cur_r.col + CLW'(1);
      end
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (obs_we) begin
      obs_mem[obs_waddr] <= obs_wdata;
    end
    obs_q_r <= obs_mem[rd_cell];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_q_r <= node_mem[rd_cell];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[path_waddr] <= trc_r;
    end
    path_q_r <= path_mem[path_raddr];
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      CS_CLR_MAP: if (sweep_last) st_nxt = CS_IDLE;
      CS_IDLE: begin
        if (start) begin
          unique case (item.kind)
            KIND_WRITE:  st_nxt = CS_WRITE;
            KIND_SEARCH: st_nxt = CS_S_CHK;
            KIND_READ:   st_nxt = CS_READ;
            default:     st_nxt = CS_DONE;
          endcase
        end
      end
      CS_WRITE:     st_nxt = CS_DONE;
      CS_READ:      st_nxt = rd_in ? CS_READ_WAIT : CS_DONE;
      CS_READ_WAIT: st_nxt = CS_DONE;
      CS_S_CHK:     st_nxt = s_oob ? CS_DONE : CS_S_GOAL;
      CS_S_GOAL:    st_nxt = obs_q_r ? CS_DONE : CS_S_SWEEP;
      CS_S_SWEEP:   if (sweep_last) st_nxt = CS_S_SEED;
      CS_S_SEED:    st_nxt = CS_POP_CHK;
      CS_POP_CHK: begin
        if (!hsts.busy) st_nxt = hsts.empty ? CS_DONE : CS_POP_WAIT;
      end
      CS_POP_WAIT:  if (!hsts.busy) st_nxt = CS_CUR;
      CS_CUR: begin
        if (node_q_r.closed) st_nxt = CS_POP_CHK;
        else if (cur_r == goal_r) st_nxt = CS_TRACE;
        else st_nxt = CS_NB;
      end
      CS_NB: begin
        if (nb_ok) st_nxt = CS_NB_CHK;
        else if (dir_r == DIR_RIGHT) st_nxt = CS_POP_CHK;
      end
      CS_NB_CHK: begin
        if (relax) st_nxt = CS_NB_WAIT;
        else st_nxt = (dir_r == DIR_RIGHT) ? CS_POP_CHK : CS_NB;
      end
      CS_NB_WAIT: begin
        if (!hsts.busy) st_nxt = (dir_r == DIR_RIGHT) ? CS_POP_CHK : CS_NB;
      end
      CS_TRACE:      st_nxt = trace_end ? CS_FILL : CS_TRACE_WAIT;
      CS_TRACE_WAIT: st_nxt = CS_TRACE;
      CS_FILL:       st_nxt = (cnt_r == '0) ? CS_DONE : CS_FILL_WAIT;
      CS_FILL_WAIT:  st_nxt = CS_FILL;
      CS_DONE:       if (res_take) st_nxt = CS_IDLE;
      default:       st_nxt = CS_IDLE;
    endcase
  end

  // datapath, memory and open list control
  always_comb begin
    item_nxt   = item_r;
    start_nxt  = start_r;
    goal_nxt   = goal_r;
    cur_nxt    = cur_r;
    nb_nxt     = nb_r;
    trc_nxt    = trc_r;
    g_nxt      = g_r;
    dir_nxt    = dir_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    res_nxt    = res_r;
    rd_cell    = cell_addr(nb_pos);
    path_raddr = AW'(item_r.step_index);
    obs_we     = 1'b0;
    obs_waddr  = AW'(cnt_r);
    obs_wdata  = 1'b0;
    node_we    = 1'b0;
    node_waddr = AW'(cnt_r);
    node_wdata = '{closed: 1'b0, cost: '1, parent: start_r};
    path_we    = 1'b0;
    path_waddr = AW'(cnt_r - (AW+1)'(1));
    hcmd       = '0;
    push_f     = FW'(ng) + cost_to_go(nb_r, goal_r);
    push_pos   = nb_r;
    unique case (st_r)
      CS_CLR_MAP: begin
        obs_we  = 1'b1;
        cnt_nxt = cnt_r + (AW+1)'(1);
      end
      CS_IDLE: begin
        if (start) begin
          item_nxt = item;
          res_nxt  = '{status: ST_OK, path_length: 12'(len_r), step_col: '0, step_row: '0};
        end
      end
      CS_WRITE: begin
        obs_we    = wr_in;
        obs_waddr = cell_addr(item_start);
        obs_wdata = item_r.blocked;
      end
      CS_READ: begin
        if (!rd_in) res_nxt.status = ST_BEYOND;
      end
      CS_READ_WAIT: begin
        res_nxt.step_col = 6'(path_q_r.col);
        res_nxt.step_row = 6'(path_q_r.row);
      end
      CS_S_CHK: begin
        len_nxt             = '0;
        res_nxt.path_length = '0;
        start_nxt           = item_start;
        goal_nxt            = item_goal;
        rd_cell             = cell_addr(item_goal);
        if (s_oob) res_nxt.status = ST_NO_PATH;
      end
      CS_S_GOAL: begin
        hcmd.clear = 1'b1;
        cnt_nxt    = '0;
        if (obs_q_r) res_nxt.status = ST_NO_PATH;
      end
      CS_S_SWEEP: begin
        node_we = 1'b1;
        cnt_nxt = cnt_r + (AW+1)'(1);
      end
      CS_S_SEED: begin
        node_we    = 1'b1;
        node_waddr = cell_addr(start_r);
        node_wdata = '{closed: 1'b0, cost: '0, parent: start_r};
        hcmd.push  = 1'b1;
        push_f     = cost_to_go(start_r, goal_r);
        push_pos   = start_r;
      end
      CS_POP_CHK: begin
        if (!hsts.busy) begin
          if (hsts.empty) res_nxt.status = ST_NO_PATH;
          else hcmd.pop = 1'b1;
        end
      end
      CS_POP_WAIT: begin
        cur_nxt = pop_pos;
        rd_cell = cell_addr(pop_pos);
      end
      CS_CUR: begin
        g_nxt   = node_q_r.cost;
        dir_nxt = DIR_UP;
        trc_nxt = goal_r;
        cnt_nxt = '0;
        if (!node_q_r.closed) begin
          node_we           = 1'b1;
          node_waddr        = cell_addr(cur_r);
          node_wdata        = node_q_r;
          node_wdata.closed = 1'b1;
        end
      end
      CS_NB: begin
        nb_nxt = nb_pos;
        if (!nb_ok) dir_nxt = dir_r + 2'd1;
      end
      CS_NB_CHK: begin
        if (relax) begin
          node_we    = 1'b1;
          node_waddr = cell_addr(nb_r);
          node_wdata = '{closed: 1'b0, cost: ng, parent: cur_r};
          hcmd.push  = 1'b1;
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end
      CS_NB_WAIT: begin
        if (!hsts.busy) dir_nxt = dir_r + 2'd1;
      end
      CS_TRACE: begin
        rd_cell = cell_addr(trc_r);
        if (trace_end) begin
          len_nxt             = cnt_r;
          res_nxt.path_length = 12'(cnt_r);
          trc_nxt             = goal_r;
        end
      end
      CS_TRACE_WAIT: begin
        trc_nxt = node_q_r.parent;
        cnt_nxt = cnt_r + (AW+1)'(1);
      end
      CS_FILL: begin
        rd_cell = cell_addr(trc_r);
        if (cnt_r != '0) begin
          path_we = 1'b1;
          cnt_nxt = cnt_r - (AW+1)'(1);
        end
      end
      CS_FILL_WAIT: begin
        trc_nxt = node_q_r.parent;
      end
      CS_DONE: begin
        hcmd = '0;
      end
      default: begin
        hcmd = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= CS_CLR_MAP;
      cnt_r <= '0;
      len_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    start_r <= start_nxt;
    goal_r  <= goal_nxt;
    cur_r   <= cur_nxt;
    nb_r    <= nb_nxt;
    trc_r   <= trc_nxt;
    g_r     <= g_nxt;
    dir_r   <= dir_nxt;
    res_r   <= res_nxt;
  end

  assign ready     = (st_r == CS_IDLE);
  assign res_valid = (st_r == CS_DONE);
  assign res_data  = res_r;

endmodule

// File: hdl/grid_astar_path_search_unit.sv
// top level of the grid path search unit: configuration, channels, result register
// depends on gaps_pkg and gaps_core
//
// Usage: shortest path search on a 4-connected grid with unit step cost.
// Input channel (in_valid / in_stall / in_data) takes one transaction per item:
// write one obstacle cell, run a search, or read one step of the stored path.
// Result channel (out_valid / out_stall / out_data) returns exactly one result
// per item, in order. The configuration port (cfg_valid / cfg_ready / cfg_index
// / cfg_data) sets grid width (index 0) and height (index 1); the user is to write
// it only while idle, which the block itself does not enforce. A search first
// sweeps the node store, then per expanded cell sifts the heap on the single read
// port of the open list memory on each push and pop, then traces the parents and
// stores the path.
// Items are handled one at a time; in_stall is high while one is in work.
// Reset: after rst_n the obstacle map is cleared one cell per cycle, all
// MAX_COLS*MAX_ROWS cells, with in_stall high; configuration writes are taken.
// A stalled result is held in the output register; the next item is accepted
// meanwhile and its result waits inside the core until the register frees.
module grid_astar_path_search_unit #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 64,
  parameter int HEAP_DEPTH = 16384
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gaps_pkg::gaps_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gaps_pkg::gaps_out_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gaps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gaps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gaps_pkg::*;

  function automatic logic [DIM_W-1:0] eff_dim(logic [CFG_DATA_W-1:0] v,
                                                logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] e;
    e = DIM_W'(v);
    if (e == '0) return DIM_W'(1);
    return (e > maxv) ? maxv : e;
  endfunction

  logic [CFG_DATA_W-1:0] grid_w_r, grid_w_nxt;
  logic [CFG_DATA_W-1:0] grid_h_r, grid_h_nxt;
  logic [DIM_W-1:0]      eff_w, eff_h;
  logic                  core_ready, res_valid, res_take;
  gaps_out_t             res_data;
  logic                  out_valid_r, out_valid_nxt;
  gaps_out_t             out_data_r, out_data_nxt;

  // configuration registers
  always_comb begin
    grid_w_nxt = grid_w_r;
    grid_h_nxt = grid_h_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_w_nxt = cfg_data;
        CFG_GRID_HEIGHT: grid_h_nxt = cfg_data;
        default:         grid_w_nxt = grid_w_r;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign eff_w     = eff_dim(grid_w_r, DIM_W'(MAX_COLS));
  assign eff_h     = eff_dim(grid_h_r, DIM_W'(MAX_ROWS));

  gaps_core #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && !in_stall),
    .item      (in_data),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .ready     (core_ready),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take)
  );

  // output register
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r    <= CFG_DIM_RESET;
      grid_h_r    <= CFG_DIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      grid_w_r    <= grid_w_nxt;
      grid_h_r    <= grid_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = !core_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // a failed search always empties the stored path
  a_nopath_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_NO_PATH)) |-> (out_data.path_length == '0))
    else $error("no-path result with nonzero length");

  // a read past the path reports no cell
  a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_BEYOND)) |->
    ((out_data.step_col == '0) && (out_data.step_row == '0)))
    else $error("beyond-length read with nonzero step");

  // output register loads only from a core result
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res_take))
    else $error("output valid without core result");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while busy");
`endif

endmodule
